// ----- rtl/hrhp_pkg.sv -----
// shared types, codes and character tables for the request header parser
package hrhp_pkg;

  // request byte counter width, saturates at all ones
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int unsigned PROD_W     = LIMIT_W + 4;

  localparam int unsigned IDX_W         = 4;
  localparam int unsigned NAME_CHARS    = 14;
  localparam int unsigned VERSION_CHARS = 5;
  localparam int unsigned IDX_MAX       = (1 << IDX_W) - 1;

  localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(8 * 1024);

  // configuration register indexes
  localparam int unsigned    CFG_IDX_W        = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEADER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY   = CFG_IDX_W'(1);

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    FLD_METHOD = 2'd0,
    FLD_TARGET = 2'd1,
    FLD_REST   = 2'd2
  } field_e;

  typedef enum logic [1:0] {
    VAL_LEAD   = 2'd0,
    VAL_DIGITS = 2'd1,
    VAL_TRAIL  = 2'd2,
    VAL_BAD    = 2'd3
  } value_e;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_MALFORMED  = 2'd2,
    ST_FINISHED   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ROLE_METHOD  = 3'd0,
    ROLE_TARGET  = 3'd1,
    ROLE_REST    = 3'd2,
    ROLE_HEADER  = 3'd3,
    ROLE_TERM    = 3'd4,
    ROLE_BODY    = 3'd5,
    ROLE_IGNORED = 3'd6
  } role_e;

  // lower case header name being matched
  function automatic logic [7:0] name_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // protocol tag that opens the version
  function automatic logic [7:0] version_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h48; // H
      4'd1:    c = 8'h54; // T
      4'd2:    c = 8'h54; // T
      4'd3:    c = 8'h50; // P
      4'd4:    c = 8'h2F; // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/http_request_header_parser.sv -----
// request header parser: byte role tagging, request line and content-length checks
// an accepted request byte's result is held in the output register from the next cycle
// throughput: one byte per cycle unless stalled; state update: one logic pass per byte
// a byte is taken while the output register is empty or being emptied in the same cycle
// reset: asynchronous active low; parser state cleared, both limits set to 8192
// op set on a byte restarts the parser without touching the limits
module http_request_header_parser
  import hrhp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LIMIT_W-1:0]   cfg_data_i,
  // request bytes in
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,  // [7:0] data_byte
  input  logic                 s_axis_tuser_i,  // [0] op
  // tagged bytes out
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o   // [1:0] status, [4:2] role,
                                                // [12:5] data_out, [28:13] body_length
);

  logic [LIMIT_W-1:0]    max_header_q, max_body_q;
  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [1:0]            crlf_q, crlf_d;
  field_e                field_q, field_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  match_q, match_d;
  value_e                val_q, val_d;
  logic [LIMIT_W-1:0]    digit_q, digit_d;
  logic [LIMIT_W-1:0]    len_q, len_d;
  logic                  bad_q, bad_d;
  logic [LIMIT_W-1:0]    left_q, left_d;
  logic [LIMIT_W-1:0]    left_dec;

  logic                  out_valid_q;
  logic [31:0]           out_data_q;

  logic                  in_accept;
  logic [7:0]            b;
  logic                  line_brk, term, is_space, is_digit;
  logic [7:0]            low_b;
  logic [PROD_W-1:0]     prod;
  status_e               status_c;
  role_e                 role_c;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;

  // byte classification
  assign line_brk = (b == CH_LF) && ((crlf_q == 2'd1) || (crlf_q == 2'd3));
  assign term     = (b == CH_LF) && (crlf_q == 2'd3);
  assign is_space = (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  assign is_digit = (b >= CH_0) && (b <= CH_9);
  assign low_b    = ((b >= CH_UP_A) && (b <= CH_UP_Z)) ? (b + CASE_OFS) : b;
  assign prod     = (PROD_W'(digit_q) << 3) + (PROD_W'(digit_q) << 1)
                    + PROD_W'(b - CH_0);
  assign left_dec = (left_q != '0) ? (left_q - LIMIT_W'(1)) : left_q;

  // next parser state and result for the byte on the input
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    crlf_d   = crlf_q;
    field_d  = field_q;
    idx_d    = idx_q;
    match_d  = match_q;
    val_d    = val_q;
    digit_d  = digit_q;
    len_d    = len_q;
    bad_d    = bad_q;
    left_d   = left_q;
    status_c = ST_INCOMPLETE;
    role_c   = ROLE_IGNORED;

    if (s_axis_tuser_i) begin
      // restart: clear everything but the limits
      phase_d = PH_LINE;
      count_d = '0;
      crlf_d  = 2'd0;
      field_d = FLD_METHOD;
      idx_d   = '0;
      match_d = 1'b1;
      val_d   = VAL_LEAD;
      digit_d = '0;
      len_d   = '0;
      bad_d   = 1'b0;
      left_d  = '0;
    end else begin
      case (phase_q)
        PH_DONE: begin
          status_c = ST_FINISHED;
        end
        PH_BODY: begin
          role_c = ROLE_BODY;
          left_d = left_dec;
          if (left_dec == '0) begin
            status_c = ST_COMPLETE;
            phase_d  = PH_DONE;
          end
        end
        default: begin
          // crlf tracker
          if (b == CH_CR) begin
            crlf_d = (crlf_q == 2'd2) ? 2'd3 : 2'd1;
          end else if ((b == CH_LF) && (crlf_q == 2'd1)) begin
            crlf_d = 2'd2;
          end else begin
            crlf_d = 2'd0;
          end

          if (phase_q == PH_LINE) begin
            // request line
            if (line_brk) begin
              if (field_q == FLD_REST) begin
                if (idx_q < IDX_W'(VERSION_CHARS)) bad_d = 1'b1;
              end else begin
                bad_d = 1'b1;
              end
              phase_d = PH_HEAD;
              idx_d   = '0;
              match_d = 1'b1;
              val_d   = VAL_LEAD;
              digit_d = '0;
              role_c  = ROLE_REST;
            end else if (field_q == FLD_METHOD || field_q == FLD_TARGET) begin
              if (b == CH_SP) begin
                if (idx_q == '0) bad_d = 1'b1;
                field_d = (field_q == FLD_METHOD) ? FLD_TARGET : FLD_REST;
                idx_d   = '0;
                role_c  = ROLE_REST;
              end else begin
                if (idx_q != IDX_W'(IDX_MAX)) idx_d = idx_q + IDX_W'(1);
                role_c = (field_q == FLD_METHOD) ? ROLE_METHOD : ROLE_TARGET;
              end
            end else begin
              if (idx_q < IDX_W'(VERSION_CHARS)) begin
                if (b == version_char(idx_q)) idx_d = idx_q + IDX_W'(1);
                else                          bad_d = 1'b1;
              end
              role_c = ROLE_REST;
            end
          end else if (term) begin
            role_c = ROLE_TERM;
          end else if (line_brk) begin
            // end of a header line: take or reject a content-length value
            if (match_q && (idx_q == IDX_W'(NAME_CHARS + 1))) begin
              if (val_q == VAL_LEAD || val_q == VAL_BAD) bad_d = 1'b1;
              else                                        len_d = digit_q;
            end
            idx_d   = '0;
            match_d = 1'b1;
            val_d   = VAL_LEAD;
            digit_d = '0;
            role_c  = ROLE_HEADER;
          end else begin
            role_c = ((b == CH_CR) && (crlf_q == 2'd2)) ? ROLE_TERM : ROLE_HEADER;
            if (match_q) begin
              if (idx_q < IDX_W'(NAME_CHARS)) begin
                if (low_b == name_char(idx_q)) idx_d   = idx_q + IDX_W'(1);
                else                           match_d = 1'b0;
              end else if (idx_q == IDX_W'(NAME_CHARS)) begin
                if (b == CH_COLON) idx_d   = IDX_W'(NAME_CHARS + 1);
                else               match_d = 1'b0;
              end else if (val_q != VAL_BAD) begin
                // value digits, trimmed of whitespace
                if (is_space) begin
                  if (val_q == VAL_DIGITS) val_d = VAL_TRAIL;
                end else if (is_digit && (val_q != VAL_TRAIL)) begin
                  if (prod > PROD_W'(max_body_q)) begin
                    val_d = VAL_BAD;
                  end else begin
                    digit_d = prod[LIMIT_W-1:0];
                    val_d   = VAL_DIGITS;
                  end
                end else begin
                  val_d = VAL_BAD;
                end
              end
            end
          end

          // terminator, size limit and byte count
          if (term) begin
            crlf_d = 2'd0;
            if (bad_d) begin
              status_c = ST_MALFORMED;
              phase_d  = PH_DONE;
            end else if (len_d == '0) begin
              status_c = ST_COMPLETE;
              phase_d  = PH_DONE;
            end else begin
              left_d  = len_d;
              phase_d = PH_BODY;
            end
          end else if (CMP_W'(count_q) >= CMP_W'(max_header_q)) begin
            status_c = ST_MALFORMED;
            phase_d  = PH_DONE;
          end else if (count_q != '1) begin
            count_d = count_q + COUNT_BITS'(1);
          end
        end
      endcase
    end
  end

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_header_q <= DEFAULT_LIMIT;
      max_body_q   <= DEFAULT_LIMIT;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_MAX_HEADER) max_header_q <= cfg_data_i;
      if (cfg_index_i == REG_MAX_BODY)   max_body_q   <= cfg_data_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE;
      count_q <= '0;
      crlf_q  <= 2'd0;
      field_q <= FLD_METHOD;
      idx_q   <= '0;
      match_q <= 1'b1;
      val_q   <= VAL_LEAD;
      digit_q <= '0;
      len_q   <= '0;
      bad_q   <= 1'b0;
      left_q  <= '0;
    end else if (in_accept) begin
      phase_q <= phase_d;
      count_q <= count_d;
      crlf_q  <= crlf_d;
      field_q <= field_d;
      idx_q   <= idx_d;
      match_q <= match_d;
      val_q   <= val_d;
      digit_q <= digit_d;
      len_q   <= len_d;
      bad_q   <= bad_d;
      left_q  <= left_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= {3'b000, len_d, b, role_c, status_c};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
